/* hw/rtl/ihex_enc_pkg.sv */
// Shared types, codes and helpers of the Intel hex record encoder.
// Depends on nothing; every other file of the block uses it by scoped names.
`default_nettype none

package ihex_enc_pkg;

  // Largest payload of one data record.
  localparam int RECORD_BYTES = 32;
  localparam int REC_CNT_W    = $clog2(RECORD_BYTES + 1);
  typedef logic [REC_CNT_W-1:0] rec_cnt_t;

  // Depth of the job queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  typedef logic [QPTR_W-1:0] qptr_t;
  typedef logic [QCNT_W-1:0] qcnt_t;

  // Request codes.
  localparam logic [1:0] REQ_CHUNK = 2'd0;
  localparam logic [1:0] REQ_DATA  = 2'd1;
  localparam logic [1:0] REQ_SHORT = 2'd2;

  localparam logic [7:0] REC_TYPE_DATA = 8'h00;

  // ASCII characters used in the text.
  localparam logic [7:0] CHR_COLON = 8'h3A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_ALPHA = 8'h37;  // 'A' minus ten

  // One record fragment to be printed by the back end.
  typedef struct packed {
    logic        has_header;
    logic [7:0]  count;
    logic [15:0] addr;
    logic [7:0]  rtype;
    logic [1:0]  npay;
    logic [15:0] payload;
    logic        has_trailer;
    logic [7:0]  csum;
    logic        line_end;
  } job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'b0000, nib};
    if (nib < 4'd10) begin
      return CHR_ZERO + wide;
    end
    return CHR_ALPHA + wide;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/ihex_enc_fifo.sv */
// Short job queue between the front and back of the hex encoder.
// Depends on ihex_enc_pkg for the job type and depth.
`default_nettype none

module ihex_enc_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire ihex_enc_pkg::job_t push_job,
  output logic                    full,
  input  wire logic               pop,
  output logic                    head_valid,
  output ihex_enc_pkg::job_t      head_job
);

  ihex_enc_pkg::job_t  slots_r [ihex_enc_pkg::QUEUE_DEPTH];
  ihex_enc_pkg::qptr_t wr_ptr_r, wr_ptr_nxt;
  ihex_enc_pkg::qptr_t rd_ptr_r, rd_ptr_nxt;
  ihex_enc_pkg::qcnt_t count_r, count_nxt;

  localparam ihex_enc_pkg::qptr_t LAST_SLOT =
    ihex_enc_pkg::qptr_t'(ihex_enc_pkg::QUEUE_DEPTH - 1);
  localparam ihex_enc_pkg::qcnt_t FULL_COUNT =
    ihex_enc_pkg::qcnt_t'(ihex_enc_pkg::QUEUE_DEPTH);

  assign full       = (count_r == FULL_COUNT);
  assign head_valid = (count_r != '0);
  assign head_job   = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("job queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("job popped from an empty queue");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r == $past(count_r) - 1'b1))
    else $error("queue count did not drop on pop");

endmodule

`default_nettype wire

/* hw/rtl/ihex_enc_front.sv */
// Front end of the hex encoder: takes input beats, tracks chunk and record
// state and turns each printing request into a job. Depends on ihex_enc_pkg.
`default_nettype none

module ihex_enc_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [1:0]    req_type,
  input  wire logic [7:0]    data_byte,
  input  wire logic [15:0]   start_address,
  input  wire logic [15:0]   chunk_length,
  input  wire logic [7:0]    short_record_type,
  input  wire logic [15:0]   short_payload,
  input  wire logic [1:0]    short_payload_bytes,
  input  wire logic          omit_line_end,
  output logic               push,
  output ihex_enc_pkg::job_t push_job
);

  logic [15:0]            next_addr_r, next_addr_nxt;
  logic [15:0]            chunk_left_r, chunk_left_nxt;
  ihex_enc_pkg::rec_cnt_t rec_left_r, rec_left_nxt;
  logic [7:0]             sum_r, sum_nxt;

  logic                   rec_open;
  logic [7:0]             rec_count;
  logic [7:0]             data_sum;
  ihex_enc_pkg::rec_cnt_t data_left;
  logic [1:0]             s_cnt;
  logic [7:0]             s_sum;
  ihex_enc_pkg::job_t     data_job, short_job;

  localparam logic [15:0] CAP16 = 16'(ihex_enc_pkg::RECORD_BYTES);
  localparam logic [7:0]  CAP8  = 8'(ihex_enc_pkg::RECORD_BYTES);

  always_comb begin
    // Data byte: open a new record when none is in progress.
    rec_open  = (rec_left_r == '0);
    rec_count = (chunk_left_r < CAP16) ? chunk_left_r[7:0] : CAP8;
    if (rec_open) begin
      data_sum  = rec_count + next_addr_r[15:8] + next_addr_r[7:0] + data_byte;
      data_left = ihex_enc_pkg::rec_cnt_t'(rec_count) - 1'b1;
    end else begin
      data_sum  = sum_r + data_byte;
      data_left = rec_left_r - 1'b1;
    end
    data_job.has_header  = rec_open;
    data_job.count       = rec_count;
    data_job.addr        = next_addr_r;
    data_job.rtype       = ihex_enc_pkg::REC_TYPE_DATA;
    data_job.npay        = 2'd1;
    data_job.payload     = {8'h00, data_byte};
    data_job.has_trailer = (data_left == '0);
    data_job.csum        = 8'h00 - data_sum;
    data_job.line_end    = 1'b1;

    // Standalone short record; a count of three is taken as two.
    s_cnt = (short_payload_bytes == 2'd3) ? 2'd2 : short_payload_bytes;
    s_sum = {6'b0, s_cnt} + start_address[15:8] + start_address[7:0]
            + short_record_type
            + ((s_cnt == 2'd2) ? short_payload[15:8] : 8'h00)
            + ((s_cnt != 2'd0) ? short_payload[7:0] : 8'h00);
    short_job.has_header  = 1'b1;
    short_job.count       = {6'b0, s_cnt};
    short_job.addr        = start_address;
    short_job.rtype       = short_record_type;
    short_job.npay        = s_cnt;
    short_job.payload     = short_payload;
    short_job.has_trailer = 1'b1;
    short_job.csum        = 8'h00 - s_sum;
    short_job.line_end    = !omit_line_end;

    next_addr_nxt  = next_addr_r;
    chunk_left_nxt = chunk_left_r;
    rec_left_nxt   = rec_left_r;
    sum_nxt        = sum_r;
    push           = 1'b0;
    push_job       = short_job;
    if (accept) begin
      unique case (req_type)
        ihex_enc_pkg::REQ_CHUNK: begin
          next_addr_nxt  = start_address;
          chunk_left_nxt = chunk_length;
          rec_left_nxt   = '0;
          sum_nxt        = 8'h00;
        end
        ihex_enc_pkg::REQ_DATA: begin
          if (chunk_left_r != 16'h0000) begin
            push           = 1'b1;
            push_job       = data_job;
            next_addr_nxt  = next_addr_r + 16'd1;
            chunk_left_nxt = chunk_left_r - 16'd1;
            rec_left_nxt   = data_left;
            sum_nxt        = data_sum;
          end
        end
        ihex_enc_pkg::REQ_SHORT: begin
          push = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_addr_r  <= '0;
      chunk_left_r <= '0;
      rec_left_r   <= '0;
      sum_r        <= '0;
    end else begin
      next_addr_r  <= next_addr_nxt;
      chunk_left_r <= chunk_left_nxt;
      rec_left_r   <= rec_left_nxt;
      sum_r        <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ihex_enc_back.sv */
// Back end of the hex encoder: walks the character positions of the job at
// the queue head and prints one character per beat. Depends on ihex_enc_pkg.
`default_nettype none

module ihex_enc_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               lf_only,
  input  wire logic               head_valid,
  input  wire ihex_enc_pkg::job_t head_job,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_text_char,
  output logic                    out_end_of_record
);

  typedef logic [4:0] pos_t;

  // Character positions within one record line.
  localparam pos_t POS_COLON = 5'd0;
  localparam pos_t POS_CNT_H = 5'd1;
  localparam pos_t POS_CNT_L = 5'd2;
  localparam pos_t POS_A3    = 5'd3;
  localparam pos_t POS_A2    = 5'd4;
  localparam pos_t POS_A1    = 5'd5;
  localparam pos_t POS_A0    = 5'd6;
  localparam pos_t POS_TYP_H = 5'd7;
  localparam pos_t POS_TYP_L = 5'd8;
  localparam pos_t POS_PH_H  = 5'd9;
  localparam pos_t POS_PH_L  = 5'd10;
  localparam pos_t POS_PL_H  = 5'd11;
  localparam pos_t POS_PL_L  = 5'd12;
  localparam pos_t POS_CS_H  = 5'd13;
  localparam pos_t POS_CS_L  = 5'd14;
  localparam pos_t POS_CR    = 5'd15;
  localparam pos_t POS_LF    = 5'd16;

  typedef struct packed {
    logic more;
    pos_t pos;
  } step_t;

  logic  active_r, active_nxt;
  pos_t  pos_r, pos_nxt;
  logic  out_valid_r, out_valid_nxt;
  logic [7:0] char_r, char_nxt;
  logic  eor_r, eor_nxt;

  pos_t  cur_pos;
  step_t nx;
  step_t after_pay;
  logic  load;

  always_comb begin
    if (head_job.has_header) begin
      cur_pos = POS_COLON;
    end else if (head_job.npay == 2'd2) begin
      cur_pos = POS_PH_H;
    end else if (head_job.npay != 2'd0) begin
      cur_pos = POS_PL_H;
    end else begin
      cur_pos = POS_CS_H;
    end
    if (active_r) begin
      cur_pos = pos_r;
    end

    after_pay = '{more: head_job.has_trailer, pos: POS_CS_H};

    unique case (cur_pos)
      POS_TYP_L: begin
        if (head_job.npay == 2'd2) begin
          nx = '{more: 1'b1, pos: POS_PH_H};
        end else if (head_job.npay != 2'd0) begin
          nx = '{more: 1'b1, pos: POS_PL_H};
        end else begin
          nx = after_pay;
        end
      end
      POS_PL_L: nx = after_pay;
      POS_CS_L: nx = '{more: head_job.line_end, pos: lf_only ? POS_LF : POS_CR};
      POS_LF:   nx = '{more: 1'b0, pos: POS_LF};
      default:  nx = '{more: 1'b1, pos: cur_pos + 5'd1};
    endcase

    unique case (cur_pos)
      POS_COLON: char_nxt = ihex_enc_pkg::CHR_COLON;
      POS_CNT_H: char_nxt = ihex_enc_pkg::hex_char(head_job.count[7:4]);
      POS_CNT_L: char_nxt = ihex_enc_pkg::hex_char(head_job.count[3:0]);
      POS_A3:    char_nxt = ihex_enc_pkg::hex_char(head_job.addr[15:12]);
      POS_A2:    char_nxt = ihex_enc_pkg::hex_char(head_job.addr[11:8]);
      POS_A1:    char_nxt = ihex_enc_pkg::hex_char(head_job.addr[7:4]);
      POS_A0:    char_nxt = ihex_enc_pkg::hex_char(head_job.addr[3:0]);
      POS_TYP_H: char_nxt = ihex_enc_pkg::hex_char(head_job.rtype[7:4]);
      POS_TYP_L: char_nxt = ihex_enc_pkg::hex_char(head_job.rtype[3:0]);
      POS_PH_H:  char_nxt = ihex_enc_pkg::hex_char(head_job.payload[15:12]);
      POS_PH_L:  char_nxt = ihex_enc_pkg::hex_char(head_job.payload[11:8]);
      POS_PL_H:  char_nxt = ihex_enc_pkg::hex_char(head_job.payload[7:4]);
      POS_PL_L:  char_nxt = ihex_enc_pkg::hex_char(head_job.payload[3:0]);
      POS_CS_H:  char_nxt = ihex_enc_pkg::hex_char(head_job.csum[7:4]);
      POS_CS_L:  char_nxt = ihex_enc_pkg::hex_char(head_job.csum[3:0]);
      POS_CR:    char_nxt = ihex_enc_pkg::CHR_CR;
      default:   char_nxt = ihex_enc_pkg::CHR_LF;
    endcase

    load = head_valid && (!out_valid_r || out_ready);
    pop  = load && !nx.more;

    active_nxt    = active_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_ready;
    eor_nxt       = !nx.more;
    if (load) begin
      out_valid_nxt = 1'b1;
      active_nxt    = nx.more;
      pos_nxt       = nx.pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      pos_r       <= POS_COLON;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= char_nxt;
      eor_r  <= eor_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_text_char     = char_r;
  assign out_end_of_record = eor_r;

endmodule

`default_nettype wire

/* hw/rtl/intel_hex_record_encoder.sv */
// Top level of the Intel hex record encoder.
// Depends on ihex_enc_pkg, ihex_enc_front, ihex_enc_fifo and ihex_enc_back.
`default_nettype none

// The encoder turns request beats into Intel hex text, one ASCII character
// per output beat. A chunk-start beat loads the load address and the byte
// count of a chunk and prints nothing. Each data byte beat of the chunk
// prints two hex digits; the byte that opens a record first prints the colon,
// count, address and type "00" (nine more characters), and the byte that
// closes a record adds the checksum and the line ending (three or four more).
// Records hold at most RECORD_BYTES bytes. A short-record beat prints a whole
// record of any type with zero to two payload bytes, eleven to seventeen
// characters. The last character caused by a beat carries end_of_record.
// Input beats are accepted one per cycle while the four-job queue between
// the front end and the printing back end has room; the back end prints one
// character per cycle while out_ready is high, so a steady stream of data
// bytes is paced by the back end. Data bytes beyond the chunk and
// the unused request code are dropped without output. The line ending
// setting must only be changed while no text is pending. No clearing pass
// is needed after reset.
module intel_hex_record_encoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [15:0] in_start_address,
  input  wire logic [15:0] in_chunk_length,
  input  wire logic [7:0]  in_short_record_type,
  input  wire logic [15:0] in_short_payload,
  input  wire logic [1:0]  in_short_payload_bytes,
  input  wire logic        in_omit_line_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_text_char,
  output logic             out_end_of_record
);

  // Line ending setting: 0 prints CR LF, 1 prints LF only.
  logic lf_only_r;

  logic               accept;
  logic               push;
  logic               full;
  logic               pop;
  logic               head_valid;
  ihex_enc_pkg::job_t push_job;
  ihex_enc_pkg::job_t head_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lf_only_r <= 1'b0;
    end else if (cfg_wr_en) begin
      lf_only_r <= cfg_wr_data;
    end
  end

  // Every accepted beat pushes at most one job, so room for one is enough.
  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  ihex_enc_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .accept              (accept),
    .req_type            (in_req_type),
    .data_byte           (in_data_byte),
    .start_address       (in_start_address),
    .chunk_length        (in_chunk_length),
    .short_record_type   (in_short_record_type),
    .short_payload       (in_short_payload),
    .short_payload_bytes (in_short_payload_bytes),
    .omit_line_end       (in_omit_line_end),
    .push                (push),
    .push_job            (push_job)
  );

  ihex_enc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  ihex_enc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .lf_only           (lf_only_r),
    .head_valid        (head_valid),
    .head_job          (head_job),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_text_char     (out_text_char),
    .out_end_of_record (out_end_of_record)
  );

endmodule

`default_nettype wire
